@@ rtl/core/avsfg_pkg.sv @@
// Shared types and constants for the AVS start-code frame grouper.
`default_nettype none

package avsfg_pkg;

  localparam int CountWidthDef = 32;
  localparam int FramesWidth   = 32;
  localparam int DistWidth     = 10;

  // Start codes of interest; anything below SC_SEQ_HDR is a slice.
  localparam logic [7:0] SC_SEQ_HDR  = 8'hB0;
  localparam logic [7:0] SC_SEQ_END  = 8'hB1;
  localparam logic [7:0] SC_USER     = 8'hB2;
  localparam logic [7:0] SC_I_PIC    = 8'hB3;
  localparam logic [7:0] SC_EXT      = 8'hB5;
  localparam logic [7:0] SC_PB_PIC   = 8'hB6;

  localparam logic [1:0] ACT_DISCARD = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_APPEND  = 2'd2;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] CT_INVALID  = 2'd0;
  localparam logic [1:0] CT_P        = 2'd1;
  localparam logic [1:0] CT_B        = 2'd2;
  localparam logic [1:0] CT_I        = 2'd3;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_FRAME  = 2'd1,
    MODE_HEADER = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] unit_code;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [7:0] byte10;
    logic [7:0] byte11;
  } item_t;

  typedef struct packed {
    logic [1:0]             action;
    logic                   prior_group_ended;
    logic [1:0]             group_kind;
    logic                   group_is_single;
    logic [1:0]             coding_type;
    logic [DistWidth-1:0]   pic_dist;
    logic [3:0]             aspect_code;
    logic [3:0]             rate_code;
    logic [FramesWidth-1:0] frames_done;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/avsfg_core.sv @@
// Grouping state machine, frame counter and per-unit decision logic.
`default_nettype none

module avsfg_core #(
  parameter int COUNT_WIDTH = avsfg_pkg::CountWidthDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire avsfg_pkg::item_t item,
  output avsfg_pkg::result_t    result
);
  import avsfg_pkg::*;

  mode_t                  mode_r, mode_nxt;
  logic                   prev_slice_r, prev_slice_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic is_slice, closes, judge, pic_start, hdr_start, end_start;
  logic [1:0] pb_type;

  assign is_slice  = item.unit_code < SC_SEQ_HDR;
  assign pic_start = (item.unit_code == SC_I_PIC) || (item.unit_code == SC_PB_PIC);
  assign hdr_start = item.unit_code == SC_SEQ_HDR;
  assign end_start = item.unit_code == SC_SEQ_END;
  assign pb_type   = item.byte6[7:6];

  // frame closes on first non-slice after a slice; header on anything but user/ext
  always_comb begin
    closes = 1'b0;
    judge  = 1'b0;
    unique case (mode_r)
      MODE_FRAME: begin
        closes = prev_slice_r && !is_slice;
        judge  = closes;
      end
      MODE_HEADER: begin
        closes = (item.unit_code != SC_EXT) && (item.unit_code != SC_USER);
        judge  = closes;
      end
      default: begin
        judge = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    prev_slice_nxt = prev_slice_r;
    count_nxt      = count_r;
    if (mode_r == MODE_FRAME && !closes) begin
      prev_slice_nxt = is_slice;
    end
    if (mode_r == MODE_FRAME && closes) begin
      count_nxt = count_r + COUNT_WIDTH'(1);
    end
    if (judge) begin
      priority if (pic_start) begin
        mode_nxt       = MODE_FRAME;
        prev_slice_nxt = 1'b0;
      end else if (hdr_start) begin
        mode_nxt = MODE_HEADER;
      end else begin
        mode_nxt = MODE_SEARCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SEARCH;
      prev_slice_r <= 1'b0;
      count_r      <= '0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      prev_slice_r <= prev_slice_nxt;
      count_r      <= count_nxt;
    end
  end

  // outputs
  always_comb begin
    result                   = '0;
    result.prior_group_ended = closes;
    result.group_kind        = KIND_NONE;
    result.action            = ACT_DISCARD;
    if (!judge) begin
      result.action     = ACT_APPEND;
      result.group_kind = (mode_r == MODE_HEADER) ? KIND_HEADER : KIND_FRAME;
    end else if (pic_start) begin
      result.action     = ACT_START;
      result.group_kind = KIND_FRAME;
      if (item.unit_code == SC_I_PIC) begin
        result.coding_type = CT_I;
      end else begin
        result.coding_type = (pb_type == CT_P || pb_type == CT_B) ? pb_type : CT_INVALID;
        result.pic_dist    = {item.byte6, item.byte7[7:6]};
      end
    end else if (hdr_start) begin
      result.action      = ACT_START;
      result.group_kind  = KIND_HEADER;
      result.aspect_code = item.byte10[5:2];
      result.rate_code   = {item.byte10[1:0], item.byte11[7:6]};
    end else if (end_start) begin
      result.action          = ACT_START;
      result.group_kind      = KIND_END;
      result.group_is_single = 1'b1;
    end
    // low bits of the counter, zero-extended when the counter is narrower
    result.frames_done = FramesWidth'(count_nxt);
  end

endmodule

`default_nettype wire

@@ rtl/core/avs_start_code_frame_grouper.sv @@
// Top level of the AVS start-code frame grouper: input and result registers around the core.
`default_nettype none

// One request per AVS start-code unit (start code plus payload bytes 6, 7, 10, 11).
// Units are grouped into frames (0xB3/0xB6 up to the first non-slice after a slice),
// sequence headers (0xB0 plus following user data / extensions) and sequence ends
// (0xB1, a group by itself). Every unit yields exactly one result request that tells
// whether it was discarded, started a group or was appended, whether it closed the
// previous group, and the decoded picture or sequence header fields. frames_done is
// the wrapping count of completed frames after this unit (low 32 bits of a
// COUNT_WIDTH-bit counter). Throughput is one unit per clock unless out_stall holds a
// full result register. A unit lands in the input register when accepted and moves
// into the result register once that register is free. The only loop is the small
// grouping state, which updates in the cycle a unit moves from the input register to
// the result register. in_stall rises only when both registers are full and
// out_stall is high.

module avs_start_code_frame_grouper #(
  parameter int COUNT_WIDTH = avsfg_pkg::CountWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_unit_code,
  input  wire logic [7:0]  in_header_byte6,
  input  wire logic [7:0]  in_header_byte7,
  input  wire logic [7:0]  in_header_byte10,
  input  wire logic [7:0]  in_header_byte11,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_action,
  output logic             out_prior_group_ended,
  output logic [1:0]       out_group_kind,
  output logic             out_group_is_single,
  output logic [1:0]       out_coding_type,
  output logic [avsfg_pkg::DistWidth-1:0]   out_pic_dist,
  output logic [3:0]       out_aspect_code,
  output logic [3:0]       out_rate_code,
  output logic [avsfg_pkg::FramesWidth-1:0] out_frames_done
);
  import avsfg_pkg::*;

  logic    in_vld_r, in_vld_nxt;
  item_t   item_r;
  logic    out_vld_r, out_vld_nxt;
  result_t res_r;
  result_t res_c;
  logic    out_free, fire, in_take;

  // result register can load when empty or being drained this cycle
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{unit_code: in_unit_code, byte6: in_header_byte6,
                  byte7: in_header_byte7, byte10: in_header_byte10,
                  byte11: in_header_byte11};
    end
    if (fire) begin
      res_r <= res_c;
    end
  end

  avsfg_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .result(res_c)
  );

  assign out_valid             = out_vld_r;
  assign out_action            = res_r.action;
  assign out_prior_group_ended = res_r.prior_group_ended;
  assign out_group_kind        = res_r.group_kind;
  assign out_group_is_single   = res_r.group_is_single;
  assign out_coding_type       = res_r.coding_type;
  assign out_pic_dist          = res_r.pic_dist;
  assign out_aspect_code       = res_r.aspect_code;
  assign out_rate_code         = res_r.rate_code;
  assign out_frames_done       = res_r.frames_done;

endmodule

`default_nettype wire
